// ===== design/sgscd_pkg.sv =====
// Shared types and constants for the debounced single-change detector.
package sgscd_pkg;

  localparam int unsigned GridSide = 8;
  localparam int unsigned ColW     = 3;
  localparam int unsigned ScanW    = GridSide * GridSide;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned OutW     = 8;
  localparam logic [CfgW-1:0] ConfirmReset = 8'd3;

  typedef struct packed {
    logic            one;
    logic            many;
    logic [ColW-1:0] col;
    logic            placed;
    logic            eq_cand;
  } lane_res_t;

  typedef struct packed {
    logic            single;
    logic            eq_cand;
    logic [ColW-1:0] col;
    logic [ColW-1:0] row;
    logic            placed;
  } merge_res_t;

endpackage

// ===== design/sgscd_lane.sv =====
// One grid row: change detection against the board and candidate match.
module sgscd_lane (
  input  logic [sgscd_pkg::GridSide-1:0] scan_i,
  input  logic [sgscd_pkg::GridSide-1:0] board_i,
  input  logic [sgscd_pkg::GridSide-1:0] cand_i,
  output sgscd_pkg::lane_res_t           res_o
);

  logic [sgscd_pkg::GridSide-1:0] diff;
  logic [sgscd_pkg::ColW-1:0]     col;
  logic                           one;

  assign diff = scan_i ^ board_i;
  assign one  = (diff != '0) && ((diff & (diff - 1'b1)) == '0);

  always_comb begin
    col = '0;
    for (int unsigned i = 0; i < sgscd_pkg::GridSide; i++) begin
      if (diff[i]) begin
        col = col | sgscd_pkg::ColW'(i);
      end
    end
  end

  assign res_o.one     = one;
  assign res_o.many    = (diff != '0) && !one;
  assign res_o.col     = col;
  assign res_o.placed  = |(scan_i & diff);
  assign res_o.eq_cand = (scan_i == cand_i);

endmodule

// ===== design/sgscd_merge.sv =====
// Combine the row lanes into one grid-wide verdict and square position.
module sgscd_merge (
  input  sgscd_pkg::lane_res_t [sgscd_pkg::GridSide-1:0] lane_i,
  output sgscd_pkg::merge_res_t                          res_o
);

  logic [sgscd_pkg::GridSide-1:0] one_v;
  logic [sgscd_pkg::GridSide-1:0] many_v;
  logic [sgscd_pkg::GridSide-1:0] eq_v;
  logic [sgscd_pkg::ColW-1:0]     row;
  logic [sgscd_pkg::ColW-1:0]     col;
  logic                           placed;

  always_comb begin
    row    = '0;
    col    = '0;
    placed = 1'b0;
    for (int unsigned i = 0; i < sgscd_pkg::GridSide; i++) begin
      one_v[i]  = lane_i[i].one;
      many_v[i] = lane_i[i].many;
      eq_v[i]   = lane_i[i].eq_cand;
      if (lane_i[i].one) begin
        row    = row | sgscd_pkg::ColW'(i);
        col    = col | lane_i[i].col;
        placed = placed | lane_i[i].placed;
      end
    end
  end

  assign res_o.single  = (one_v != '0) && ((one_v & (one_v - 1'b1)) == '0) && (many_v == '0);
  assign res_o.eq_cand = &eq_v;
  assign res_o.col     = col;
  assign res_o.row     = row;
  assign res_o.placed  = placed;

endmodule

// ===== design/sensor_grid_single_change_debounce.sv =====
// Top level of the debounced single-change detector for an 8x8 sensor grid.
// Takes one 64-bit scan per clock cycle when not stalled, gives at most one
// result per scan, registered in the next cycle. Eight row lanes compare the
// scan with the stored board and the candidate in the same cycle, and the
// merge stage finds the single changed square; the state update for the next
// scan closes in that cycle. s_axis_tready is low only while a result waits in
// the output register and m_axis_tready is low. The first scan after reset
// loads the board and gives no result. confirm_scans may only be written while
// no scan is in flight.
module sensor_grid_single_change_debounce (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sgscd_pkg::CfgW-1:0]      cfg_wdata_i,   // confirm_scans
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sgscd_pkg::ScanW-1:0]     s_axis_tdata,  // [63:0] scan_bits
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sgscd_pkg::OutW-1:0]      m_axis_tdata   // [2:0] square_column,
                                                         // [5:3] square_row,
                                                         // [6] piece_placed, [7] zero
);

  localparam int unsigned G = sgscd_pkg::GridSide;

  logic [sgscd_pkg::CfgW-1:0]  confirm_q;
  logic [sgscd_pkg::ScanW-1:0] board_q, board_d;
  logic [sgscd_pkg::ScanW-1:0] cand_q, cand_d;
  logic                        loaded_q, loaded_d;
  logic                        confirming_q, confirming_d;
  logic [sgscd_pkg::CfgW-1:0]  agree_q, agree_d;
  logic [sgscd_pkg::CfgW-1:0]  agree_inc;
  logic                        out_valid_q;
  logic [sgscd_pkg::OutW-1:0]  out_data_q;
  logic                        emit;
  logic                        take;

  sgscd_pkg::lane_res_t [G-1:0] lane_res;
  sgscd_pkg::merge_res_t        merged;

  for (genvar r = 0; r < G; r++) begin : g_lane
    sgscd_lane u_lane (
      .scan_i  (s_axis_tdata[r*G +: G]),
      .board_i (board_q[r*G +: G]),
      .cand_i  (cand_q[r*G +: G]),
      .res_o   (lane_res[r])
    );
  end

  sgscd_merge u_merge (
    .lane_i (lane_res),
    .res_o  (merged)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign agree_inc     = agree_q + 1'b1;

  always_comb begin
    board_d      = board_q;
    cand_d       = cand_q;
    loaded_d     = loaded_q;
    confirming_d = confirming_q;
    agree_d      = agree_q;
    emit         = 1'b0;
    if (take) begin
      if (!loaded_q) begin
        board_d  = s_axis_tdata;
        loaded_d = 1'b1;
      end else if (confirming_q) begin
        if (!merged.eq_cand) begin
          confirming_d = 1'b0;
          agree_d      = '0;
        end else if (agree_inc >= confirm_q) begin
          emit         = 1'b1;
          board_d      = cand_q;
          confirming_d = 1'b0;
          agree_d      = '0;
        end else begin
          agree_d = agree_inc;
        end
      end else if (merged.single) begin
        cand_d  = s_axis_tdata;
        agree_d = '0;
        if (confirm_q == '0) begin
          emit    = 1'b1;
          board_d = s_axis_tdata;
        end else begin
          confirming_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q    <= sgscd_pkg::ConfirmReset;
      board_q      <= '0;
      cand_q       <= '0;
      loaded_q     <= 1'b0;
      confirming_q <= 1'b0;
      agree_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        confirm_q <= cfg_wdata_i;
      end
      board_q      <= board_d;
      cand_q       <= cand_d;
      loaded_q     <= loaded_d;
      confirming_q <= confirming_d;
      agree_q      <= agree_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {1'b0, merged.placed, merged.row, merged.col};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== tb/tb_sensor_grid_single_change_debounce.sv =====
// Testbench for the debounced single-change detector: predicted square changes checked per result.
`timescale 1ns / 100ps

module tb_sensor_grid_single_change_debounce;

  localparam int unsigned IdlePct      = 14;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned NumPhases    = 9;

  typedef struct packed {
    logic                       placed;
    logic [sgscd_pkg::ColW-1:0] row;
    logic [sgscd_pkg::ColW-1:0] col;
  } square_change_t;

  class change_scoreboard;
    logic [sgscd_pkg::ScanW-1:0] board;
    logic [sgscd_pkg::ScanW-1:0] candidate;
    bit                          loaded;
    bit                          confirming;
    logic [sgscd_pkg::CfgW-1:0]  confirm_scans;
    logic [sgscd_pkg::CfgW-1:0]  agree_count;
    square_change_t              pending[$];
    int unsigned                 mistakes;

    function new();
      board         = '0;
      candidate     = '0;
      loaded        = 1'b0;
      confirming    = 1'b0;
      confirm_scans = sgscd_pkg::ConfirmReset;
      agree_count   = '0;
      mistakes      = 0;
    endfunction

    function void set_confirm(logic [sgscd_pkg::CfgW-1:0] value);
      confirm_scans = value;
    endfunction

    function void commit_candidate();
      logic [sgscd_pkg::ScanW-1:0] diff;
      int unsigned                 idx;
      square_change_t              chg;
      diff = board ^ candidate;
      idx  = 0;
      while (idx < sgscd_pkg::ScanW - 1 && !diff[idx]) idx++;
      chg.col    = sgscd_pkg::ColW'(idx % sgscd_pkg::GridSide);
      chg.row    = sgscd_pkg::ColW'(idx / sgscd_pkg::GridSide);
      chg.placed = candidate[idx];
      pending    = {pending, chg};
      board       = candidate;
      confirming  = 1'b0;
      agree_count = '0;
    endfunction

    function void take_scan(logic [sgscd_pkg::ScanW-1:0] scan);
      logic [sgscd_pkg::ScanW-1:0] diff;
      if (!loaded) begin
        board  = scan;
        loaded = 1'b1;
        return;
      end
      if (confirming) begin
        if (scan != candidate) begin
          confirming  = 1'b0;
          agree_count = '0;
          return;
        end
        agree_count = agree_count + 1'b1;
        if (agree_count >= confirm_scans) commit_candidate();
        return;
      end
      diff = board ^ scan;
      if ($countones(diff) == 1) begin
        candidate   = scan;
        confirming  = 1'b1;
        agree_count = '0;
        if (confirm_scans == 0) commit_candidate();
      end
    endfunction

    function void check_change(logic [sgscd_pkg::OutW-1:0] data);
      square_change_t want;
      square_change_t got;
      got = data[6:0];
      if (pending.size() == 0) begin
        $display("%0t: result expected none actual col %0d row %0d placed %0d",
                 $time, got.col, got.row, got.placed);
        mistakes++;
        return;
      end
      want = pending.pop_front();
      if (got.col != want.col) begin
        $display("%0t: square_column expected %0d actual %0d", $time, want.col, got.col);
        mistakes++;
      end
      if (got.row != want.row) begin
        $display("%0t: square_row expected %0d actual %0d", $time, want.row, got.row);
        mistakes++;
      end
      if (got.placed != want.placed) begin
        $display("%0t: piece_placed expected %0d actual %0d", $time, want.placed, got.placed);
        mistakes++;
      end
    endfunction
  endclass

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_we_i      = 1'b0;
  logic [sgscd_pkg::CfgW-1:0]  cfg_wdata_i   = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [sgscd_pkg::ScanW-1:0] s_axis_tdata  = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [sgscd_pkg::OutW-1:0]  m_axis_tdata;

  logic        calm      = 1'b0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned scans_sent   = 0;

  int unsigned confirm_plan [NumPhases] = '{2, 0, 1, 255, 3, 7, 1, 0, 4};
  int unsigned budget_plan [NumPhases]  = '{150, 150, 150, 600, 150, 150, 150, 150, 150};

  change_scoreboard sb = new();

  always #2 clk_i = ~clk_i;

  sensor_grid_single_change_debounce dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_change(m_axis_tdata);
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left     <= HoldCycles;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_sensor_grid_single_change_debounce: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_scan(input logic [sgscd_pkg::ScanW-1:0] scan);
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= scan;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_scan(scan);
    scans_sent++;
  endtask

  task automatic write_confirm(input logic [sgscd_pkg::CfgW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_confirm(value);
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned                 stop_at;
    int unsigned                 agrees;
    int unsigned                 b1;
    bit                          broken;
    logic [sgscd_pkg::ScanW-1:0] cand;
    stop_at = scans_sent + budget;
    while (scans_sent < stop_at) begin
      if ($urandom_range(99) < 75) begin
        // drop any candidate left over from a broken request run
        if (sb.confirming) send_scan(sb.board);
        cand   = sb.board ^ (64'd1 << $urandom_range(sgscd_pkg::ScanW - 1));
        agrees = 32'(sb.confirm_scans);
        broken = 1'b0;
        if (agrees != 0 && $urandom_range(99) < 15) begin
          agrees = $urandom_range(agrees - 1);
          broken = 1'b1;
        end
        send_scan(cand);
        repeat (agrees) send_scan(cand);
        if (broken) send_scan(cand ^ (64'd1 << $urandom_range(sgscd_pkg::ScanW - 1)));
      end else begin
        case ($urandom_range(3))
          0: send_scan({$urandom, $urandom});
          1: send_scan(sb.board);
          2: begin
            b1 = $urandom_range(sgscd_pkg::ScanW - 1);
            send_scan(sb.board ^ (64'd1 << b1)
                      ^ (64'd1 << ((b1 + 1 + $urandom_range(sgscd_pkg::ScanW - 2))
                                   % sgscd_pkg::ScanW)));
          end
          default: send_scan($urandom_range(1) ? '1 : '0);
        endcase
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_scan('0);
    repeat (4) send_scan(64'd1);
    send_scan('1);
    send_scan((64'd1 << 63) | 64'd1);
    send_scan(64'd1);
    send_scan(64'd1);
    repeat (4) send_scan('0);

    write_confirm(8'd0);
    send_scan(64'd1 << 63);
    send_scan(64'd1 << 63);
    send_scan('0);

    write_confirm(8'd5);
    repeat (3) send_scan(64'd1 << 27);
    // lower the threshold while a candidate is half confirmed
    write_confirm(8'd1);
    send_scan(64'd1 << 27);

    for (int p = 0; p < NumPhases; p++) begin
      write_confirm(sgscd_pkg::CfgW'(confirm_plan[p]));
      calm <= (confirm_plan[p] == 3);
      if (confirm_plan[p] == 0) hold_req <= 1'b1;
      run_phase(budget_plan[p]);
    end

    s_axis_tvalid <= 1'b0;
    calm          <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (sb.mistakes == 0 && sb.pending.size() == 0) begin
      $display("tb_sensor_grid_single_change_debounce: clean");
    end else begin
      $display("tb_sensor_grid_single_change_debounce: errors");
    end
    $finish;
  end

endmodule
